/* hdl/htfc_pkg.sv */
`timescale 1ns / 1ps

package htfc_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_CRC    = 2'd2;

    // CRC-8 constants
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Byte positions within a frame
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;
    localparam logic [2:0] FRAME_LEN    = 3'd6;
    localparam logic [2:0] COUNT_MAX    = 3'd7;

    // Scaling constants
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // One finished frame, as handed from the front to the back
    typedef struct packed {
        logic [1:0]  status;
        logic        temp_bad;
        logic [15:0] temp_raw;
        logic [15:0] humid_raw;
    } frame_t;

    // Fold one byte into the CRC-8 accumulator, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/htfc_front.sv */
`timescale 1ns / 1ps

module htfc_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                last_byte,
    output logic                push,
    output htfc_pkg::frame_t    push_frame
);

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    logic        temp_bad_reg, temp_bad_next;
    logic        humid_bad_reg, humid_bad_next;
    logic        accept;

    assign accept = in_valid && !in_stall;

    // Advance the frame state by one byte
    always_comb
    begin
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        crc_next        = crc_reg;
        temp_bad_next   = temp_bad_reg;
        humid_bad_next  = humid_bad_reg;
        case (byte_count_reg)
            htfc_pkg::POS_TEMP_HI, htfc_pkg::POS_TEMP_LO:
            begin
                temp_word_next = {temp_word_reg[7:0], rx_byte};
                crc_next       = htfc_pkg::crc8_byte(crc_reg, rx_byte);
            end
            htfc_pkg::POS_TEMP_CRC:
            begin
                temp_bad_next = (rx_byte != crc_reg);
                crc_next      = htfc_pkg::CRC_INIT;
            end
            htfc_pkg::POS_HUM_HI, htfc_pkg::POS_HUM_LO:
            begin
                humid_word_next = {humid_word_reg[7:0], rx_byte};
                crc_next        = htfc_pkg::crc8_byte(crc_reg, rx_byte);
            end
            htfc_pkg::POS_HUM_CRC:
            begin
                humid_bad_next = (rx_byte != crc_reg);
                crc_next       = htfc_pkg::CRC_INIT;
            end
            default:
            begin
            end
        endcase
        byte_count_next = (byte_count_reg == htfc_pkg::COUNT_MAX) ?
                          htfc_pkg::COUNT_MAX : byte_count_reg + 3'd1;
    end

    // Classify the frame on its last byte
    always_comb
    begin
        push = accept && last_byte;
        if (byte_count_next != htfc_pkg::FRAME_LEN)
        begin
            push_frame.status    = htfc_pkg::STATUS_LENGTH;
            push_frame.temp_bad  = 1'b0;
            push_frame.temp_raw  = 16'd0;
            push_frame.humid_raw = 16'd0;
        end
        else
        begin
            push_frame.status    = (temp_bad_next || humid_bad_next) ?
                                   htfc_pkg::STATUS_CRC : htfc_pkg::STATUS_OK;
            push_frame.temp_bad  = temp_bad_next;
            push_frame.temp_raw  = temp_word_next;
            push_frame.humid_raw = humid_word_next;
        end
    end

    // Hold frame state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 3'd0;
            crc_reg        <= htfc_pkg::CRC_INIT;
            temp_word_reg  <= 16'd0;
            humid_word_reg <= 16'd0;
            temp_bad_reg   <= 1'b0;
            humid_bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg <= 3'd0;
                crc_reg        <= htfc_pkg::CRC_INIT;
                temp_word_reg  <= 16'd0;
                humid_word_reg <= 16'd0;
                temp_bad_reg   <= 1'b0;
                humid_bad_reg  <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                temp_word_reg  <= temp_word_next;
                humid_word_reg <= humid_word_next;
                temp_bad_reg   <= temp_bad_next;
                humid_bad_reg  <= humid_bad_next;
            end
        end
    end

    // A new frame always starts from a cleared state
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (byte_count_reg == 3'd0 && crc_reg == htfc_pkg::CRC_INIT))
        else $error("frame state not cleared after last byte");

endmodule

/* hdl/htfc_queue.sv */
`timescale 1ns / 1ps

module htfc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  htfc_pkg::frame_t    push_frame,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop,
    output htfc_pkg::frame_t    pop_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    htfc_pkg::frame_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_frame = mem[rd_ptr_reg];

    // Write the entry at the tail
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from empty queue");

endmodule

/* hdl/htfc_back.sv */
`timescale 1ns / 1ps

module htfc_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    input  htfc_pkg::frame_t    pop_frame,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [15:0]         temperature_raw,
    output logic [15:0]         humidity_raw,
    output logic signed [14:0]  temperature_centi,
    output logic [13:0]         humidity_centi
);

    logic              s1_valid_reg;
    htfc_pkg::frame_t  s1_frame_reg;
    logic [30:0]       t_prod_reg;
    logic [29:0]       h_prod_reg;
    logic              s1_adv, s2_load;

    logic              s2_valid_reg;
    logic [1:0]        status_reg;
    logic [15:0]       t_raw_reg, h_raw_reg;
    logic [14:0]       t_centi_reg;
    logic [13:0]       h_centi_reg;

    logic [16:0]       t_sum, h_sum;
    logic [14:0]       t_quot;
    logic [13:0]       h_quot;

    assign s2_load = !s2_valid_reg || !out_stall;
    assign s1_adv  = !s1_valid_reg || s2_load;
    assign pop     = pop_valid && s1_adv;

    // Stage 1: scale raw words by the span constants
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_frame_reg <= pop_frame;
            t_prod_reg   <= 31'(pop_frame.temp_raw) * 31'(htfc_pkg::TEMP_SPAN);
            h_prod_reg   <= 30'(pop_frame.humid_raw) * 30'(htfc_pkg::HUM_SPAN);
        end
    end

    // Divide by 65535: x = a*65536 + b gives a + (a+b >= 65535)
    always_comb
    begin
        t_sum  = 17'(t_prod_reg[30:16]) + 17'(t_prod_reg[15:0]);
        h_sum  = 17'(h_prod_reg[29:16]) + 17'(h_prod_reg[15:0]);
        t_quot = t_prod_reg[30:16] + 15'(t_sum >= htfc_pkg::FULL_SCALE);
        h_quot = h_prod_reg[29:16] + 14'(h_sum >= htfc_pkg::FULL_SCALE);
    end

    // Stage 2: offset, zero the special cases and hold the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            status_reg <= s1_frame_reg.status;
            t_raw_reg  <= s1_frame_reg.temp_raw;
            h_raw_reg  <= s1_frame_reg.humid_raw;
            if (s1_frame_reg.status == htfc_pkg::STATUS_LENGTH)
            begin
                t_centi_reg <= 15'd0;
                h_centi_reg <= 14'd0;
            end
            else
            begin
                t_centi_reg <= t_quot - htfc_pkg::TEMP_OFFSET;
                h_centi_reg <= s1_frame_reg.temp_bad ? 14'd0 : h_quot;
            end
        end
    end

    assign out_valid         = s2_valid_reg;
    assign status            = status_reg;
    assign temperature_raw   = t_raw_reg;
    assign humidity_raw      = h_raw_reg;
    assign temperature_centi = $signed(t_centi_reg);
    assign humidity_centi    = h_centi_reg;

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == htfc_pkg::STATUS_LENGTH) |->
        (temperature_centi == 15'sd0 && humidity_centi == 14'd0))
        else $error("wrong-length result carries nonzero values");

    a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (humidity_centi <= htfc_pkg::HUM_SPAN))
        else $error("humidity out of range");

endmodule

/* hdl/humidity_temp_frame_checker.sv */
`timescale 1ns / 1ps

// Sensor read-back frame checker.
// Input channel: one frame byte per transaction (rx_byte) with last_byte set
// on the final byte; in_valid / in_stall handshake. A frame is temperature
// word, its CRC-8, humidity word, its CRC-8 (poly 0x31, init 0xFF).
// Output channel: one result transaction per frame (status, raw words and
// scaled centi values); out_valid / out_stall handshake.
// Throughput: one byte per cycle while in_stall is low; the front CRC unit
// folds a byte per cycle too. A frame passes the queue write, then the
// multiply stage, then the divide/offset stage; out_stall holds the back.
// Finished frames wait in a QUEUE_DEPTH-entry queue ahead of the two back
// stages. When out_stall holds the back, the queue fills; once it is full,
// in_stall rises until an entry drains. Bytes that do not end a frame are
// stalled too while the queue is full.
// Reset clears the frame state (count 0, CRC 0xFF, words and flags zero),
// empties the queue and drops any result in flight.
module humidity_temp_frame_checker
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [15:0]         temperature_raw,
    output logic [15:0]         humidity_raw,
    output logic signed [14:0]  temperature_centi,
    output logic [13:0]         humidity_centi
);

    logic              push, full, pop_valid, pop;
    htfc_pkg::frame_t  push_frame, pop_frame;

    assign in_stall = full;

    htfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .last_byte  (last_byte),
        .push       (push),
        .push_frame (push_frame)
    );

    htfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_frame  (pop_frame)
    );

    htfc_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_frame         (pop_frame),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .temperature_raw   (temperature_raw),
        .humidity_raw      (humidity_raw),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

endmodule

/* tb/htfc_frame_monitor.sv */
`timescale 1ns / 1ps

package htfc_tb_pkg;

    import htfc_pkg::*;

    // Content of one result transaction as the monitor expects it
    typedef struct {
        logic [1:0]         status;
        logic [15:0]        temp_raw;
        logic [15:0]        humid_raw;
        logic signed [14:0] temp_centi;
        logic [13:0]        humid_centi;
    } frame_result_t;

    // Advance a CRC-8 (poly 0x31) by one byte, MSB first
    function automatic logic [7:0] sensor_crc8(input logic [7:0] seed, input logic [7:0] data);
        logic [7:0] r;
        logic       msb;
        r = seed ^ data;
        repeat (8)
        begin
            msb = r[7];
            r   = r << 1;
            if (msb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

module htfc_frame_monitor
    import htfc_pkg::*;
    import htfc_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               last_byte,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         status,
    input  logic [15:0]        temperature_raw,
    input  logic [15:0]        humidity_raw,
    input  logic signed [14:0] temperature_centi,
    input  logic [13:0]        humidity_centi,
    output int                 mismatch_count,
    output int                 results_pending,
    output int                 results_ok,
    output int                 results_length,
    output int                 results_crc
);

    // Frame state of the predictor
    logic [2:0]    bytes_seen;
    logic [7:0]    crc_run;
    logic [15:0]   temp_acc;
    logic [15:0]   humid_acc;
    logic          temp_bad;
    logic          humid_bad;
    frame_result_t expected_frames[$];
    frame_result_t want;

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
        results_ok      = 0;
        results_length  = 0;
        results_crc     = 0;
    end

    task automatic clear_frame();
        bytes_seen = '0;
        crc_run    = CRC_INIT;
        temp_acc   = '0;
        humid_acc  = '0;
        temp_bad   = 1'b0;
        humid_bad  = 1'b0;
    endtask

    // Fold one accepted byte into the frame; on the last byte queue the result
    task automatic absorb_byte(input logic [7:0] b, input logic ends_frame);
        frame_result_t r;
        int            t_scaled;
        int            h_scaled;
        case (bytes_seen)
            POS_TEMP_HI, POS_TEMP_LO:
            begin
                temp_acc = {temp_acc[7:0], b};
                crc_run  = sensor_crc8(crc_run, b);
            end
            POS_TEMP_CRC:
            begin
                temp_bad = (b != crc_run);
                crc_run  = CRC_INIT;
            end
            POS_HUM_HI, POS_HUM_LO:
            begin
                humid_acc = {humid_acc[7:0], b};
                crc_run   = sensor_crc8(crc_run, b);
            end
            POS_HUM_CRC:
            begin
                humid_bad = (b != crc_run);
                crc_run   = CRC_INIT;
            end
            default:
            begin
            end
        endcase
        if (bytes_seen != COUNT_MAX)
        begin
            bytes_seen = bytes_seen + 3'd1;
        end
        if (ends_frame)
        begin
            if (bytes_seen != FRAME_LEN)
            begin
                r.status      = STATUS_LENGTH;
                r.temp_raw    = '0;
                r.humid_raw   = '0;
                r.temp_centi  = '0;
                r.humid_centi = '0;
            end
            else
            begin
                // Scale with exact integer division, offset after the floor
                t_scaled      = (17500 * int'(temp_acc)) / 65535 - 4500;
                h_scaled      = (10000 * int'(humid_acc)) / 65535;
                r.status      = (temp_bad || humid_bad) ? STATUS_CRC : STATUS_OK;
                r.temp_raw    = temp_acc;
                r.humid_raw   = humid_acc;
                r.temp_centi  = t_scaled[14:0];
                r.humid_centi = temp_bad ? 14'd0 : h_scaled[13:0];
            end
            expected_frames.push_back(r);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input int expected_val, input int actual_val);
        if (expected_val != actual_val)
        begin
            $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
            mismatch_count++;
        end
    endtask

    // Compare each result transaction, then predict from each byte transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            expected_frames.delete();
            results_pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("result transaction with none expected: status %0d", status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("status", want.status, status);
                    check_field("temperature_raw", want.temp_raw, temperature_raw);
                    check_field("humidity_raw", want.humid_raw, humidity_raw);
                    check_field("temperature_centi", want.temp_centi, temperature_centi);
                    check_field("humidity_centi", want.humid_centi, humidity_centi);
                    case (want.status)
                        STATUS_OK:     results_ok++;
                        STATUS_LENGTH: results_length++;
                        default:       results_crc++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                absorb_byte(rx_byte, last_byte);
            end
            results_pending = expected_frames.size();
        end
    end

endmodule

/* tb/tb_humidity_temp_frame_checker.sv */
`timescale 1ns / 1ps

module tb_humidity_temp_frame_checker;

    import htfc_pkg::*;
    import htfc_tb_pkg::*;

    localparam int TOTAL_BYTES  = 600;
    localparam int DRAIN_CYCLES = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte = 8'd0;
    logic               last_byte = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [15:0]        temperature_raw;
    logic [15:0]        humidity_raw;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;

    int mismatch_count;
    int results_pending;
    int results_ok;
    int results_length;
    int results_crc;
    int bytes_sent = 0;
    int frames_sent = 0;
    bit in_idle_on = 1'b1;
    bit out_idle_on = 1'b1;

    humidity_temp_frame_checker i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .temperature_raw   (temperature_raw),
        .humidity_raw      (humidity_raw),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi)
    );

    htfc_frame_monitor i_monitor
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .last_byte         (last_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .temperature_raw   (temperature_raw),
        .humidity_raw      (humidity_raw),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .mismatch_count    (mismatch_count),
        .results_pending   (results_pending),
        .results_ok        (results_ok),
        .results_length    (results_length),
        .results_crc       (results_crc)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return sensor_crc8(sensor_crc8(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Favor the scale extremes now and then
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Idle a random number of cycles, then hold the byte until it is taken
    task automatic drive_byte(input logic [7:0] b, input logic ends_frame);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 10) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= b;
        last_byte <= ends_frame;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Build a frame from two words, flip CRC bits as asked, cut or pad to len
    task automatic send_frame(input logic [15:0] t, input logic [15:0] h,
                              input logic [7:0] t_flip, input logic [7:0] h_flip,
                              input int len);
        logic [7:0] frame_q[$];
        frame_q = {t[15:8], t[7:0], word_crc(t) ^ t_flip,
                   h[15:8], h[7:0], word_crc(h) ^ h_flip};
        while (frame_q.size() > len)
        begin
            void'(frame_q.pop_back());
        end
        while (frame_q.size() < len)
        begin
            frame_q.push_back(8'($urandom));
        end
        for (int i = 0; i < len; i++)
        begin
            drive_byte(frame_q[i], i == len - 1);
        end
        frames_sent++;
    endtask

    // Hold off the sender until every queued result has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
    endtask

    // Byte source
    initial
    begin
        int sel;
        int len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: scale extremes, each CRC failure, short and saturating frames
        send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h01, 6);
        send_frame(16'hFFFF, 16'h0000, 8'h80, 8'h00, 6);
        send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 6);
        send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1);
        send_frame(16'hABCD, 16'h8001, 8'h00, 8'h00, 8);
        hold_until_drained();

        // Random: mostly well-formed frames, some broken ones and noise
        while (bytes_sent < TOTAL_BYTES)
        begin
            if (frames_sent % 30 == 0)
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                hold_until_drained();
            end
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 6);
            end
            else if (sel < 63)
            begin
                send_frame(pick_word(), pick_word(), 8'($urandom_range(1, 255)), 8'h00, 6);
            end
            else if (sel < 71)
            begin
                send_frame(pick_word(), pick_word(), 8'h00, 8'($urandom_range(1, 255)), 6);
            end
            else if (sel < 76)
            begin
                send_frame(pick_word(), pick_word(), 8'($urandom_range(1, 255)),
                           8'($urandom_range(1, 255)), 6);
            end
            else if (sel < 84)
            begin
                send_frame(pick_word(), pick_word(), 8'h00, 8'h00, $urandom_range(1, 5));
            end
            else if (sel < 92)
            begin
                send_frame(pick_word(), pick_word(), 8'h00, 8'h00, $urandom_range(7, 12));
            end
            else
            begin
                // Noise: random bytes, ended at a random length
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    drive_byte(8'($urandom), i == len - 1);
                end
                frames_sent++;
            end
        end

        // Drain the last results, then let the pipeline settle
        in_valid <= 1'b0;
        do @(posedge clk); while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d frames in %0d bytes, with random gaps on both sides.",
                 frames_sent, bytes_sent);
        $display("Results checked: %0d ok, %0d wrong length, %0d CRC mismatch.",
                 results_ok, results_length, results_crc);
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("humidity_temp_frame_checker test passed");
        end
        else
        begin
            $display("humidity_temp_frame_checker test failed");
        end
        $finish;
    end

    // Result sink: stall a random number of cycles before each transaction
    initial
    begin
        int stall_cycles;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall_cycles = out_idle_on ? $urandom_range(0, 10) : 0;
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("humidity_temp_frame_checker test failed");
        $finish;
    end

endmodule
